FILE: src/normal_basis_blend_alpha_unit_macros.svh
// Assertion macros for the normal basis blend alpha unit.
// Included by the top level; depends on nothing else.
`ifndef NORMAL_BASIS_BLEND_ALPHA_UNIT_MACROS_SVH
`define NORMAL_BASIS_BLEND_ALPHA_UNIT_MACROS_SVH

// General clocked property, disabled while reset is asserted.
`define NBBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("nbba assertion failed");

// A condition that must never hold outside reset.
`define NBBA_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("nbba forbidden condition");

`endif

FILE: src/nbba_pkg.sv
// Shared constants for the normal basis blend alpha pipeline.
// Used by nbba_dot, nbba_ratio and the top level; depends on nothing.
package nbba_pkg;

  localparam int CH_W     = 8;
  localparam int IDX_W    = 5;
  localparam int ALPHA_W  = 3;
  localparam int DOT_W    = 24;
  localparam int MAG_W    = 21;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int DIV_W    = 48;
  localparam int LATENCY  = 6;

  // Basis coefficients in Q12.
  localparam logic signed [DOT_W-1:0] COEF_S = 24'sd3547;
  localparam logic signed [DOT_W-1:0] COEF_H = 24'sd1774;
  localparam logic signed [DOT_W-1:0] COEF_Q = 24'sd3072;
  localparam logic signed [DOT_W-1:0] COEF_Z = 24'sd2048;

endpackage

FILE: src/nbba_dot.sv
// Dot products with the three basis vectors, clamp and square.
// Two register stages; depends on nbba_pkg.
module nbba_dot import nbba_pkg::*; (
  input  logic              clk,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  output logic [SQ_W-1:0]   sq0,
  output logic [SQ_W-1:0]   sq1,
  output logic [SQ_W-1:0]   sq2
);

  logic signed [DOT_W-1:0] vx, vy, vz;
  logic signed [DOT_W-1:0] dot0_nxt, dot1_nxt, dot2_nxt;
  logic signed [DOT_W-1:0] dot0_r, dot1_r, dot2_r;
  logic [MAG_W-1:0] m0, m1, m2;
  logic [SQ_W-1:0] sq0_r, sq1_r, sq2_r;

  function automatic logic [MAG_W-1:0] clamp_pos(input logic signed [DOT_W-1:0] d);
    logic [MAG_W-1:0] res;
    res = (d > 0) ? d[MAG_W-1:0] : '0;
    return res;
  endfunction

  always_comb begin
    vx = $signed({{(DOT_W-CH_W-1){1'b0}}, red, 1'b0}) - 24'sd255;
    vy = 24'sd255 - $signed({{(DOT_W-CH_W-1){1'b0}}, green, 1'b0});
    vz = $signed({{(DOT_W-CH_W-1){1'b0}}, blue, 1'b0}) - 24'sd255;
    dot0_nxt = COEF_S * vx + COEF_Z * vz;
    dot1_nxt = COEF_Q * vy - COEF_H * vx + COEF_Z * vz;
    dot2_nxt = COEF_Z * vz - COEF_H * vx - COEF_Q * vy;
    m0 = clamp_pos(dot0_r);
    m1 = clamp_pos(dot1_r);
    m2 = clamp_pos(dot2_r);
  end

  always_ff @(posedge clk) begin
    dot0_r <= dot0_nxt;
    dot1_r <= dot1_nxt;
    dot2_r <= dot2_nxt;
    sq0_r  <= SQ_W'(m0) * SQ_W'(m0);
    sq1_r  <= SQ_W'(m1) * SQ_W'(m1);
    sq2_r  <= SQ_W'(m2) * SQ_W'(m2);
  end

  assign sq0 = sq0_r;
  assign sq1 = sq1_r;
  assign sq2 = sq2_r;

endmodule

FILE: src/nbba_ratio.sv
// Three-stage restoring divider giving a 3-bit truncated quotient.
// One quotient bit per stage; depends on nbba_pkg.
module nbba_ratio import nbba_pkg::*; (
  input  logic               clk,
  input  logic [DIV_W-1:0]   numer,
  input  logic [DIV_W-1:0]   denom,
  input  logic               zero,
  output logic [ALPHA_W-1:0] alpha
);

  logic [DIV_W-1:0] rem1_r, rem2_r, den1_r, den2_r;
  logic [DIV_W-1:0] rem1_nxt, rem2_nxt;
  logic [DIV_W-1:0] sub2, sub1;
  logic             q2_r, zero1_r, zero2_r;
  logic [1:0]       q21_r;
  logic             q2_nxt, q1_nxt, q0_nxt;
  logic [ALPHA_W-1:0] alpha_r;

  always_comb begin
    sub2     = denom << 2;
    q2_nxt   = numer >= sub2;
    rem1_nxt = q2_nxt ? numer - sub2 : numer;
    sub1     = den1_r << 1;
    q1_nxt   = rem1_r >= sub1;
    rem2_nxt = q1_nxt ? rem1_r - sub1 : rem1_r;
    q0_nxt   = rem2_r >= den2_r;
  end

  always_ff @(posedge clk) begin
    rem1_r  <= rem1_nxt;
    den1_r  <= denom;
    q2_r    <= q2_nxt;
    zero1_r <= zero;
    rem2_r  <= rem2_nxt;
    den2_r  <= den1_r;
    q21_r   <= {q2_r, q1_nxt};
    zero2_r <= zero1_r;
    alpha_r <= zero2_r ? '0 : {q21_r, q0_nxt};
  end

  assign alpha = alpha_r;

endmodule

FILE: src/normal_basis_blend_alpha_unit.sv
// Top level of the normal basis blend alpha unit.
// Uses nbba_pkg, nbba_dot, nbba_ratio and the assertion macro header.
//
//   channel | ports                                   | handshake
//   input   | in_normal_red/green/blue, in_color_index | start, busy
//   result  | out_first_texel, out_second_texel       | out_valid strobe
//
// One word is accepted every cycle; busy is always low.
// Each result passes the dot-product and square registers, then the sum
// registers, then the divider steps.
// Reset clears the valid chain only. The receiver cannot stall.
`include "normal_basis_blend_alpha_unit_macros.svh"
module normal_basis_blend_alpha_unit import nbba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CH_W-1:0]  in_normal_red,
  input  logic [CH_W-1:0]  in_normal_green,
  input  logic [CH_W-1:0]  in_normal_blue,
  input  logic [IDX_W-1:0] in_color_index,
  output logic             out_valid,
  output logic [CH_W-1:0]  out_first_texel,
  output logic [CH_W-1:0]  out_second_texel
);

  logic [LATENCY-1:0] valid_r;
  logic [IDX_W-1:0]   idx_r [LATENCY];
  logic [SQ_W-1:0]    sq0, sq1, sq2;
  logic [DIV_W-1:0]   num2_r, den2_r, num3_r, den3_r;
  logic               zero2_r, zero3_r;
  logic [DIV_W-1:0]   sum2, sum3;
  logic [ALPHA_W-1:0] alpha2, alpha3;

  assign busy = 1'b0;

  nbba_dot u_dot (
    .clk   (clk),
    .red   (in_normal_red),
    .green (in_normal_green),
    .blue  (in_normal_blue),
    .sq0   (sq0),
    .sq1   (sq1),
    .sq2   (sq2)
  );

  always_comb begin
    sum2 = DIV_W'(sq0) + DIV_W'(sq1);
    sum3 = sum2 + DIV_W'(sq2);
  end

  always_ff @(posedge clk) begin
    num2_r  <= (DIV_W'(sq1) * DIV_W'(14)) + sum2;
    den2_r  <= sum2 << 1;
    zero2_r <= (sq1 == '0);
    num3_r  <= (DIV_W'(sq2) * DIV_W'(14)) + sum3;
    den3_r  <= sum3 << 1;
    zero3_r <= (sq2 == '0);
  end

  nbba_ratio u_ratio2 (
    .clk   (clk),
    .numer (num2_r),
    .denom (den2_r),
    .zero  (zero2_r),
    .alpha (alpha2)
  );

  nbba_ratio u_ratio3 (
    .clk   (clk),
    .numer (num3_r),
    .denom (den3_r),
    .zero  (zero3_r),
    .alpha (alpha3)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[LATENCY-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= in_color_index;
    for (int i = 1; i < LATENCY; i++) begin
      idx_r[i] <= idx_r[i-1];
    end
  end

  assign out_valid        = valid_r[LATENCY-1];
  assign out_first_texel  = {alpha2, idx_r[LATENCY-1]};
  assign out_second_texel = {alpha3, idx_r[LATENCY-1]};

  `NBBA_ASSERT(a_word_emerges, clk, rst_n, start |-> ##6 out_valid)
  `NBBA_ASSERT(a_no_phantom, clk, rst_n, out_valid |-> $past(start, 6))
  `NBBA_NEVER(a_never_busy, clk, rst_n, busy)

endmodule

FILE: bench/normal_basis_blend_alpha_unit_test.sv
// Self-checking bench for the normal basis blend alpha unit: drives texel words
// and compares both packed alpha bytes against a built-in predictor.
// Depends on nbba_pkg and the normal_basis_blend_alpha_unit RTL.
`timescale 1ns / 100ps
module normal_basis_blend_alpha_unit_test;
  import nbba_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [IDX_W-1:0] index;
  } texel_word_t;

  typedef struct packed {
    logic [CH_W-1:0] first;
    logic [CH_W-1:0] second;
  } blend_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CH_W-1:0] in_normal_red = '0;
  logic [CH_W-1:0] in_normal_green = '0;
  logic [CH_W-1:0] in_normal_blue = '0;
  logic [IDX_W-1:0] in_color_index = '0;
  logic out_valid;
  logic [CH_W-1:0] out_first_texel;
  logic [CH_W-1:0] out_second_texel;

  texel_word_t pending_texels[$];
  blend_pair_t expected_pairs[$];
  int send_idle_pct = 0;
  int mismatch_count = 0;
  int pairs_checked = 0;
  bit stimulus_done = 1'b0;

  normal_basis_blend_alpha_unit i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [ALPHA_W-1:0] blend_alpha(longint unsigned num,
                                                     longint unsigned den);
    longint unsigned a;
    if (num == 0 || den == 0) return '0;
    a = (14 * num + den) / (2 * den);
    return (a > 7) ? 3'd7 : a[ALPHA_W-1:0];
  endfunction

  function automatic longint unsigned clamp_sq(longint d);
    return (d <= 0) ? 0 : longint'(d) * longint'(d);
  endfunction

  function automatic blend_pair_t predict_blend(texel_word_t w);
    longint vx, vy, vz;
    longint unsigned d0, d1, d2;
    blend_pair_t p;
    vx = 2 * longint'(w.red) - 255;
    vy = 255 - 2 * longint'(w.green);
    vz = 2 * longint'(w.blue) - 255;
    d0 = clamp_sq(3547 * vx + 2048 * vz);
    d1 = clamp_sq(-1774 * vx + 3072 * vy + 2048 * vz);
    d2 = clamp_sq(-1774 * vx - 3072 * vy + 2048 * vz);
    p.first = {blend_alpha(d1, d0 + d1), w.index};
    p.second = {blend_alpha(d2, d0 + d1 + d2), w.index};
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [CH_W-1:0] got,
                                 logic [CH_W-1:0] want);
    $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_pairs.push_back(predict_blend({in_normal_red, in_normal_green,
                                              in_normal_blue, in_color_index}));
    end
    if (!rst_n || (start && busy)) begin
    end else if (pending_texels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      texel_word_t w;
      w = pending_texels.pop_front();
      start <= 1'b1;
      {in_normal_red, in_normal_green, in_normal_blue, in_color_index} <= w;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected word", out_first_texel, '0);
      end else begin
        blend_pair_t e;
        e = expected_pairs.pop_front();
        if (out_first_texel !== e.first)
          report_mismatch("first_texel", out_first_texel, e.first);
        if (out_second_texel !== e.second)
          report_mismatch("second_texel", out_second_texel, e.second);
        pairs_checked++;
      end
    end
  end

  task automatic queue_texel(int r, int g, int b, int idx);
    texel_word_t w;
    w.red = CH_W'(r);
    w.green = CH_W'(g);
    w.blue = CH_W'(b);
    w.index = IDX_W'(idx);
    pending_texels.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_texels.size() != 0 || start) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    queue_texel(0, 0, 0, 0);
    queue_texel(255, 255, 255, 31);
    queue_texel(255, 128, 128, 1);
    queue_texel(128, 128, 255, 2);
    queue_texel(0, 128, 128, 3);
    queue_texel(0, 0, 128, 4);
    queue_texel(0, 255, 128, 5);
    queue_texel(128, 0, 255, 6);
    queue_texel(128, 255, 255, 7);
    queue_texel(127, 128, 0, 8);
    queue_texel(128, 127, 128, 16);
    queue_texel(170, 85, 85, 21);
    queue_texel(85, 170, 170, 10);
    queue_texel(0, 0, 255, 30);
    queue_texel(255, 0, 0, 15);
    queue_texel(0, 255, 0, 17);
    queue_texel(64, 192, 200, 9);
    queue_texel(200, 64, 50, 24);
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 79 : 0;
      for (int n = 0; n < 650; n++) begin
        if ($urandom_range(3) == 0)
          queue_texel($urandom, $urandom, $urandom, $urandom);
        else
          queue_texel($urandom_range(90, 165), $urandom_range(90, 165),
                      $urandom_range(128, 255), $urandom);
      end
      wait_drained();
    end
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Checked %0d texel words over three idle mixes, directed corners first.",
             pairs_checked);
    if (mismatch_count == 0) begin
      $display("normal_basis_blend_alpha_unit verification clean");
    end else begin
      $display("normal_basis_blend_alpha_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("normal_basis_blend_alpha_unit verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+src
src/nbba_pkg.sv
src/nbba_dot.sv
src/nbba_ratio.sv
src/normal_basis_blend_alpha_unit.sv
bench/normal_basis_blend_alpha_unit_test.sv
